// ===== design/calclk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calclk_pkg
// Shared types, key codes and arithmetic helpers for the calendar clock.
// ----------------------------------------------------------------------------
package calclk_pkg;

    localparam logic [4:0] KEY_NONE  = 5'd0;
    localparam logic [4:0] KEY_ENTER = 5'd4;
    localparam logic [4:0] KEY_LEAVE = 5'd8;
    localparam logic [4:0] KEY_UP    = 5'd12;
    localparam logic [4:0] KEY_MIL   = 5'd13;
    localparam logic [4:0] KEY_ZERO  = 5'd14;
    localparam logic [4:0] KEY_CIV   = 5'd15;
    localparam logic [4:0] KEY_DOWN  = 5'd16;

    localparam logic [3:0] CURSOR_LAST = 4'd13;

    localparam logic [13:0] YEAR_RESET = 14'd1970;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    // The year never passes 11819 here, so the quotient by 1970 is always 5.
    localparam logic [13:0] YEAR_FOLD  = 14'd7880;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_INC,
        ST_N_SEC,
        ST_N_MIN,
        ST_N_HR,
        ST_N_MON,
        ST_N_DAY,
        ST_N_YR,
        ST_RUN_KEY,
        ST_EDIT,
        ST_FINISH
    } calclk_state_t;

    typedef struct packed {
        logic take_key;
        logic enter_set;
        logic leave_set;
        logic inc_sec;
        logic norm_sec;
        logic norm_min;
        logic norm_hr;
        logic norm_mon;
        logic norm_day;
        logic norm_yr;
        logic run_key;
        logic edit;
        logic load_out;
    } calclk_cmd_t;

    typedef struct packed {
        logic mode;
        logic prev_enter;
        logic prev_leave;
        logic hr_over;
        logic mon_over;
        logic day_over;
    } calclk_status_t;

    // Quotient by 10 of a 7-bit value, exact below 1024.
    function automatic logic [3:0] div10_7(input logic [6:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return 4'(p >> 11);
    endfunction

    // Quotient by 12 of a 7-bit value, exact below 512.
    function automatic logic [3:0] div12_7(input logic [6:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd171;
        return 4'(p >> 11);
    endfunction

    function automatic logic [10:0] div10_14(input logic [13:0] y);
        logic [29:0] p;
        p = 30'(y) * 30'd52429;
        return 11'(p >> 19);
    endfunction

    function automatic logic [7:0] div100_14(input logic [13:0] y);
        logic [29:0] p;
        p = 30'(y) * 30'd20972;
        return 8'(p >> 21);
    endfunction

    function automatic logic [4:0] div1000_14(input logic [13:0] y);
        logic [27:0] p;
        p = 28'(y) * 28'd8389;
        return 5'(p >> 23);
    endfunction

    function automatic logic [3:0] key_digit(input logic [4:0] k);
        logic [3:0] d;
        case (k)
            5'd1:    d = 4'd1;
            5'd2:    d = 4'd2;
            5'd3:    d = 4'd3;
            5'd5:    d = 4'd4;
            5'd6:    d = 4'd5;
            5'd7:    d = 4'd6;
            5'd9:    d = 4'd7;
            5'd10:   d = 4'd8;
            5'd11:   d = 4'd9;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [13:0] y, input logic [6:0] m);
        logic [7:0]  q100;
        logic [13:0] r100;
        logic        leap;
        logic [4:0]  len;
        q100 = div100_14(y);
        r100 = y - 14'(q100) * 14'd100;
        if (r100 == 14'd0)
        begin
            leap = (q100[1:0] == 2'b00);
        end
        else
        begin
            leap = (y[1:0] == 2'b00);
        end
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

// ===== design/calendar_clock_with_digit_setting.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_with_digit_setting
// Calendar clock ticked by keypad words, with a digit-by-digit setting mode.
// ----------------------------------------------------------------------------
// Each input word is one tick carrying a keypad code. The block takes a word
// when in_valid is high and in_stall is low, and answers each tick with one
// output word holding the date, time, display flags and cursor.
// One tick is handled at a time. A plain running tick passes through the
// second increment, the carry steps and the key step before the output
// word; an edit tick takes the edit step only. The carry loops repeat the
// month and day steps for each pass over a month length, the month step
// for each wrap of the month by twelve and the hour step for each 24 hours
// folded into a day; leaving setting mode runs the carry chain twice. in_stall
// is high from acceptance until the result is moved into the output register.
// The output register holds the word while out_stall is high; a finished
// tick waits for it to empty before it is loaded, and no new tick is taken
// in the meantime.
// Reset sets 1970-01-01 00:00:00, running mode, 24-hour display, cursor 0,
// and leaves no output word pending.
// ----------------------------------------------------------------------------
module calendar_clock_with_digit_setting (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  key_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] year_value,
    output logic [6:0]  month_value,
    output logic [6:0]  day_value,
    output logic [6:0]  hour_value,
    output logic [6:0]  minute_value,
    output logic [6:0]  second_value,
    output logic [3:0]  hour_twelve,
    output logic        is_pm,
    output logic        setting_mode,
    output logic [3:0]  cursor_digit,
    output logic        military_display
);
    import calclk_pkg::*;

    calclk_cmd_t    cmd;
    calclk_status_t status;

    calclk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    calclk_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .key_code         (key_code),
        .year_value       (year_value),
        .month_value      (month_value),
        .day_value        (day_value),
        .hour_value       (hour_value),
        .minute_value     (minute_value),
        .second_value     (second_value),
        .hour_twelve      (hour_twelve),
        .is_pm            (is_pm),
        .setting_mode     (setting_mode),
        .cursor_digit     (cursor_digit),
        .military_display (military_display)
    );

endmodule

// ===== design/calclk_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calclk_ctrl
// Sequencer for one tick: mode change, second increment, carry steps, key.
// ----------------------------------------------------------------------------
module calclk_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    input  calclk_pkg::calclk_status_t status,
    output calclk_pkg::calclk_cmd_t  cmd
);
    import calclk_pkg::*;

    calclk_state_t state_reg, state_next;
    logic          run_after_reg, run_after_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_after_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_after_reg <= run_after_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        run_after_next = run_after_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!status.mode && status.prev_enter)
                begin
                    state_next = ST_EDIT;
                end
                else if (status.mode && status.prev_leave)
                begin
                    state_next     = ST_N_SEC;
                    run_after_next = 1'b1;
                end
                else if (!status.mode)
                begin
                    state_next = ST_INC;
                end
                else
                begin
                    state_next = ST_EDIT;
                end
            end
            ST_INC:
            begin
                state_next     = ST_N_SEC;
                run_after_next = 1'b0;
            end
            ST_N_SEC: state_next = ST_N_MIN;
            ST_N_MIN: state_next = ST_N_HR;
            ST_N_HR:
            begin
                if (!status.hr_over)
                begin
                    state_next = ST_N_MON;
                end
            end
            ST_N_MON:
            begin
                if (!status.mon_over)
                begin
                    state_next = ST_N_DAY;
                end
            end
            ST_N_DAY: state_next = status.day_over ? ST_N_MON : ST_N_YR;
            ST_N_YR:  state_next = run_after_reg ? ST_INC : ST_RUN_KEY;
            ST_RUN_KEY: state_next = ST_FINISH;
            ST_EDIT:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:    cmd.take_key = in_valid;
            ST_START:
            begin
                cmd.enter_set = !status.mode && status.prev_enter;
                cmd.leave_set = status.mode && status.prev_leave;
            end
            ST_INC:     cmd.inc_sec  = 1'b1;
            ST_N_SEC:   cmd.norm_sec = 1'b1;
            ST_N_MIN:   cmd.norm_min = 1'b1;
            ST_N_HR:    cmd.norm_hr  = 1'b1;
            ST_N_MON:   cmd.norm_mon = 1'b1;
            ST_N_DAY:   cmd.norm_day = 1'b1;
            ST_N_YR:    cmd.norm_yr  = 1'b1;
            ST_RUN_KEY: cmd.run_key  = 1'b1;
            ST_EDIT:    cmd.edit     = 1'b1;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ===== design/calclk_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calclk_dp
// Date and time registers, carry arithmetic, digit editing and output word.
// ----------------------------------------------------------------------------
module calclk_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  calclk_pkg::calclk_cmd_t   cmd,
    output calclk_pkg::calclk_status_t status,
    input  logic [4:0]                key_code,
    output logic [13:0]               year_value,
    output logic [6:0]                month_value,
    output logic [6:0]                day_value,
    output logic [6:0]                hour_value,
    output logic [6:0]                minute_value,
    output logic [6:0]                second_value,
    output logic [3:0]                hour_twelve,
    output logic                      is_pm,
    output logic                      setting_mode,
    output logic [3:0]                cursor_digit,
    output logic                      military_display
);
    import calclk_pkg::*;

    logic        mode_reg, mode_next;
    logic [3:0]  cursor_reg, cursor_next;
    logic [4:0]  prev_key_reg, prev_key_next;
    logic [4:0]  cur_key_reg;
    logic        mil_reg, mil_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;

    logic [13:0] year_out_reg;
    logic [6:0]  month_out_reg, day_out_reg, hour_out_reg, minute_out_reg, second_out_reg;
    logic [3:0]  twelve_out_reg, cursor_out_reg;
    logic        pm_out_reg, mode_out_reg, mil_out_reg;

    logic [4:0]  len;
    logic [3:0]  d;
    logic [10:0] q10;
    logic [7:0]  q100;
    logic [4:0]  q1000;
    logic [3:0]  hq;
    logic [6:0]  hr12;

    assign len   = month_len(year_reg, month_reg);
    assign d     = key_digit(cur_key_reg);
    assign q10   = div10_14(year_reg);
    assign q100  = div100_14(year_reg);
    assign q1000 = div1000_14(year_reg);
    assign hq    = div12_7(hour_reg);
    assign hr12  = hour_reg - 7'(hq) * 7'd12;

    assign status.mode       = mode_reg;
    assign status.prev_enter = (prev_key_reg == KEY_ENTER);
    assign status.prev_leave = (prev_key_reg == KEY_LEAVE);
    assign status.hr_over    = (hour_reg > 7'd23);
    assign status.mon_over   = (month_reg > 7'd12);
    assign status.day_over   = (day_reg > 7'(len));

    // Replace the ones digit of a two-digit field.
    function automatic logic [6:0] set_ones(input logic [6:0] v, input logic [3:0] dg);
        logic [6:0] lo;
        lo = v - 7'(div10_7(v)) * 7'd10;
        return v - lo + 7'(dg);
    endfunction

    // Replace the tens digit; anything above the tens is dropped.
    function automatic logic [6:0] set_tens(input logic [6:0] v, input logic [3:0] dg);
        logic [6:0] lo;
        lo = v - 7'(div10_7(v)) * 7'd10;
        return 7'(dg) * 7'd10 + lo;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            cursor_reg   <= 4'd0;
            prev_key_reg <= KEY_NONE;
            mil_reg      <= 1'b1;
            year_reg     <= YEAR_RESET;
            month_reg    <= 7'd1;
            day_reg      <= 7'd1;
            hour_reg     <= 7'd0;
            minute_reg   <= 7'd0;
            second_reg   <= 7'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            cursor_reg   <= cursor_next;
            prev_key_reg <= prev_key_next;
            mil_reg      <= mil_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_key)
        begin
            // Codes above the keypad range count as no key.
            cur_key_reg <= (key_code > KEY_DOWN) ? KEY_NONE : key_code;
        end
        if (cmd.load_out)
        begin
            year_out_reg   <= year_reg;
            month_out_reg  <= month_reg;
            day_out_reg    <= day_reg;
            hour_out_reg   <= hour_reg;
            minute_out_reg <= minute_reg;
            second_out_reg <= second_reg;
            twelve_out_reg <= (hr12 == 7'd0) ? 4'd12 : hr12[3:0];
            pm_out_reg     <= (hour_reg >= 7'd12);
            mode_out_reg   <= mode_reg;
            cursor_out_reg <= cursor_reg;
            mil_out_reg    <= mil_reg;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        cursor_next   = cursor_reg;
        prev_key_next = prev_key_reg;
        mil_next      = mil_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;

        if (cmd.enter_set)
        begin
            mode_next   = 1'b1;
            cursor_next = 4'd0;
        end
        if (cmd.leave_set)
        begin
            mode_next   = 1'b0;
            cursor_next = 4'd0;
        end
        if (cmd.inc_sec)
        begin
            second_next = second_reg + 7'd1;
        end
        // Seconds and minutes stay below 120, so one subtraction carries fully.
        if (cmd.norm_sec && second_reg > 7'd59)
        begin
            second_next = second_reg - 7'd60;
            minute_next = minute_reg + 7'd1;
        end
        if (cmd.norm_min && minute_reg > 7'd59)
        begin
            minute_next = minute_reg - 7'd60;
            hour_next   = hour_reg + 7'd1;
        end
        if (cmd.norm_hr && status.hr_over)
        begin
            hour_next = hour_reg - 7'd24;
            day_next  = day_reg + 7'd1;
        end
        if (cmd.norm_mon && status.mon_over)
        begin
            month_next = month_reg - 7'd12;
            year_next  = year_reg + 14'd1;
        end
        if (cmd.norm_day && status.day_over)
        begin
            day_next   = day_reg - 7'(len);
            month_next = month_reg + 7'd1;
        end
        if (cmd.norm_yr && year_reg > YEAR_MAX)
        begin
            year_next = year_reg - YEAR_FOLD;
        end
        if (cmd.run_key)
        begin
            prev_key_next = cur_key_reg;
            if (cur_key_reg == KEY_MIL)
            begin
                mil_next = 1'b1;
            end
            else if (cur_key_reg == KEY_CIV)
            begin
                mil_next = 1'b0;
            end
        end
        if (cmd.edit)
        begin
            prev_key_next = cur_key_reg;
            case (cur_key_reg)
                KEY_NONE, KEY_ENTER, KEY_LEAVE:
                begin
                end
                KEY_UP:   cursor_next = (cursor_reg >= CURSOR_LAST) ? 4'd0 : cursor_reg + 4'd1;
                KEY_DOWN: cursor_next = (cursor_reg == 4'd0) ? CURSOR_LAST : cursor_reg - 4'd1;
                KEY_MIL:  mil_next = 1'b1;
                KEY_CIV:  mil_next = 1'b0;
                default:
                begin
                    case (cursor_reg)
                        4'd0:  second_next = set_ones(second_reg, d);
                        4'd1:  second_next = set_tens(second_reg, d);
                        4'd2:  minute_next = set_ones(minute_reg, d);
                        4'd3:  minute_next = set_tens(minute_reg, d);
                        4'd4:  hour_next   = set_ones(hour_reg, d);
                        4'd5:  hour_next   = set_tens(hour_reg, d);
                        4'd6:  year_next   = 14'(q10) * 14'd10 + 14'(d);
                        4'd7:  year_next   = 14'(q100) * 14'd100 + 14'(d) * 14'd10
                                             + (year_reg - 14'(q10) * 14'd10);
                        4'd8:  year_next   = 14'(q1000) * 14'd1000 + 14'(d) * 14'd100
                                             + (year_reg - 14'(q100) * 14'd100);
                        4'd9:  year_next   = 14'(d) * 14'd1000
                                             + (year_reg - 14'(q1000) * 14'd1000);
                        4'd10: day_next    = set_ones(day_reg, d);
                        4'd11: day_next    = set_tens(day_reg, d);
                        4'd12: month_next  = set_ones(month_reg, d);
                        4'd13: month_next  = set_tens(month_reg, d);
                        default: cursor_next = 4'd0;
                    endcase
                end
            endcase
        end
    end

    assign year_value       = year_out_reg;
    assign month_value      = month_out_reg;
    assign day_value        = day_out_reg;
    assign hour_value       = hour_out_reg;
    assign minute_value     = minute_out_reg;
    assign second_value     = second_out_reg;
    assign hour_twelve      = twelve_out_reg;
    assign is_pm            = pm_out_reg;
    assign setting_mode     = mode_out_reg;
    assign cursor_digit     = cursor_out_reg;
    assign military_display = mil_out_reg;

endmodule
